### rtl/boxavg_pkg.sv
// ----------------------------------------------------------------------------
// boxavg_pkg: shared types and codes of the box average downscaler
// Holds field widths, register indexes, the controller states and the
// result record.
// ----------------------------------------------------------------------------
package boxavg_pkg;

  localparam int PIX_W  = 16;
  localparam int POS_W  = 8;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 8'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_PUSH,
    ST_CFG_GO,
    ST_CFG_WAIT
  } state_t;

  // recompute steps after a register write
  typedef enum logic [2:0] {
    CS_FA,
    CS_FD,
    CS_COL,
    CS_ROW,
    CS_POS
  } cfg_step_t;

  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [PIX_W-1:0] mean;
    logic             last;
  } res_t;

endpackage

### rtl/boxavg_in_if.sv
// ----------------------------------------------------------------------------
// boxavg_in_if: pixel request channel
// Valid/ready channel carrying one input pixel and its frame start flag.
// ----------------------------------------------------------------------------
interface boxavg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_value;
  logic        frame_start;

  modport source(output valid, pixel_value, frame_start, input ready);
  modport sink(input valid, pixel_value, frame_start, output ready);
endinterface

### rtl/boxavg_out_if.sv
// ----------------------------------------------------------------------------
// boxavg_out_if: result request channel
// Valid/ready channel carrying one block average and its position.
// ----------------------------------------------------------------------------
interface boxavg_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_col;
  logic [7:0]  out_row;
  logic [15:0] mean_value;
  logic        frame_last;

  modport source(output valid, out_col, out_row, mean_value, frame_last, input ready);
  modport sink(input valid, out_col, out_row, mean_value, frame_last, output ready);
endinterface

### rtl/boxavg_cfg_if.sv
// ----------------------------------------------------------------------------
// boxavg_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface boxavg_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/box_average_downscaler_unit.sv
// ----------------------------------------------------------------------------
// box_average_downscaler_unit: box average downscaler
// Accumulates per-column block sums in a memory and emits one mean per block.
// ----------------------------------------------------------------------------
// A pixel that adds to no sum and emits nothing stays in ST_IDLE, one that does a
// read-modify-write of the column sum memory visits ST_UPD, a degenerate zero
// result ST_PUSH, and one closing a block ST_UPD, ST_DIV and ST_PUSH, the mean
// coming from the bit-serial divider (SW = SAMPLE_BITS + 2*FW bits); a stalled
// result adds its wait. A write to a known register recomputes factors and
// positions. Reset (rst_n low, synchronous) sets 36 x 36 outputs, position 0,0.
module box_average_downscaler_unit import boxavg_pkg::*; #(
  parameter int IMAGE_SIZE  = 144,
  parameter int SAMPLE_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  boxavg_in_if.sink     in_bus,
  boxavg_out_if.source  out_bus,
  boxavg_cfg_if.sink    cfg_bus
);

  localparam int PW        = $clog2(IMAGE_SIZE);
  localparam int FW        = $clog2(IMAGE_SIZE + 1);
  localparam int SUM_DEPTH = IMAGE_SIZE / 2;
  localparam int AW        = $clog2(SUM_DEPTH);
  localparam int SW        = SAMPLE_BITS + 2 * FW;
  localparam int CW        = (PW > POS_W) ? PW + 1 : POS_W + 1;
  localparam int RESET_FACTOR = IMAGE_SIZE / 36;
  localparam logic [PIX_W-1:0] SMASK =
    (SAMPLE_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << SAMPLE_BITS) - 1);

  state_t    state_r, state_nxt;
  cfg_step_t step_r, step_nxt;

  logic [POS_W-1:0] ow_r, oh_r;
  logic [FW-1:0]    fa_r, fd_r, lc_r, lr_r;
  logic [2*FW-1:0]  area_r;
  logic [PW-1:0]    c_r, r_r, bc_r, br_r;
  logic [POS_W-1:0] dcol_r;
  logic [POS_W:0]   drow_r;

  logic [SW-1:0] sample_r;
  logic          first_r, lastb_r;
  logic [AW-1:0] addr_r;
  res_t          res_r, out_r;
  logic          out_valid_r;

  // current position, after frame start
  logic             fs;
  logic [PW-1:0]    cc, rr, bc_c, br_c;
  logic [FW-1:0]    lc_c, lr_c;
  logic [POS_W-1:0] dcol_c;
  logic [POS_W:0]   drow_c;

  assign fs     = in_bus.frame_start;
  assign cc     = fs ? '0 : c_r;
  assign rr     = fs ? '0 : r_r;
  assign bc_c   = fs ? '0 : bc_r;
  assign br_c   = fs ? '0 : br_r;
  assign lc_c   = fs ? '0 : lc_r;
  assign lr_c   = fs ? '0 : lr_r;
  assign dcol_c = fs ? '0 : dcol_r;
  assign drow_c = fs ? '0 : drow_r;

  logic deg, deg_hit, region, first_c, lastb_c, lastf_c;
  assign deg     = (fa_r < FW'(2)) || (fd_r < FW'(2));
  assign deg_hit = (ow_r != '0) && (drow_c < {1'b0, oh_r});
  assign region  = (CW'(bc_c) < CW'(ow_r)) && (CW'(br_c) < CW'(oh_r)) &&
                   (bc_c < PW'(SUM_DEPTH));
  assign first_c = (lc_c == '0) && (lr_c == '0);
  assign lastb_c = (lc_c == fa_r - 1'b1) && (lr_c == fd_r - 1'b1);
  assign lastf_c = (CW'(bc_c) == CW'(ow_r) - 1'b1) && (CW'(br_c) == CW'(oh_r) - 1'b1);

  // advance position counters
  logic [PW-1:0]    c_nxt, r_nxt, bc_nxt, br_nxt;
  logic [FW-1:0]    lc_nxt, lr_nxt;
  logic [POS_W-1:0] dcol_nxt;
  logic [POS_W:0]   drow_nxt;
  logic             row_end, frame_end;

  assign row_end   = (cc == PW'(IMAGE_SIZE - 1));
  assign frame_end = row_end && (rr == PW'(IMAGE_SIZE - 1));

  always_comb begin
    c_nxt = cc + 1'b1; lc_nxt = lc_c + 1'b1; bc_nxt = bc_c;
    r_nxt = rr;        lr_nxt = lr_c;        br_nxt = br_c;
    if (lc_nxt == fa_r) begin
      lc_nxt = '0;
      bc_nxt = bc_c + 1'b1;
    end
    if (row_end) begin
      c_nxt = '0; lc_nxt = '0; bc_nxt = '0;
      if (frame_end) begin
        r_nxt = '0; lr_nxt = '0; br_nxt = '0;
      end else begin
        r_nxt  = rr + 1'b1;
        lr_nxt = lr_c + 1'b1;
        if (lr_nxt == fd_r) begin
          lr_nxt = '0;
          br_nxt = br_c + 1'b1;
        end
      end
    end
    dcol_nxt = dcol_c + 1'b1;
    drow_nxt = drow_c;
    if (frame_end) begin
      dcol_nxt = '0;
      drow_nxt = '0;
    end else if (dcol_nxt == ow_r) begin
      dcol_nxt = '0;
      if (drow_c != {1'b1, {POS_W{1'b0}}}) drow_nxt = drow_c + 1'b1;
    end
  end

  // sum memory
  logic [SW-1:0] rd_data, new_sum;
  logic          mem_we;
  assign new_sum = first_r ? sample_r : rd_data + sample_r;
  assign mem_we  = (state_r == ST_UPD);

  boxavg_mem #(.DEPTH(SUM_DEPTH), .W(SW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr_r),
    .wdata (new_sum),
    .raddr (bc_c[AW-1:0]),
    .rdata (rd_data)
  );

  // divider operand select
  logic [SW-1:0] div_dvd, div_dvs, cfg_dvd, cfg_dvs, div_q, div_rm;
  logic [2*PW-1:0] pos_w;
  logic div_start, div_done, cfg_zero;

  assign pos_w = {{PW{1'b0}}, r_r} * (2*PW)'(IMAGE_SIZE) + (2*PW)'(c_r);

  always_comb begin
    unique case (step_r)
      CS_FA:   begin cfg_dvd = SW'(IMAGE_SIZE); cfg_dvs = SW'(ow_r); end
      CS_FD:   begin cfg_dvd = SW'(IMAGE_SIZE); cfg_dvs = SW'(oh_r); end
      CS_COL:  begin cfg_dvd = SW'(c_r);        cfg_dvs = SW'(fa_r); end
      CS_ROW:  begin cfg_dvd = SW'(r_r);        cfg_dvs = SW'(fd_r); end
      CS_POS:  begin cfg_dvd = SW'(pos_w);      cfg_dvs = SW'(ow_r); end
      default: begin cfg_dvd = '0;              cfg_dvs = '0;        end
    endcase
  end

  assign cfg_zero = (cfg_dvs == '0);
  assign div_dvd  = (state_r == ST_UPD) ? new_sum : cfg_dvd;
  assign div_dvs  = (state_r == ST_UPD) ? SW'(area_r) : cfg_dvs;

  boxavg_div #(.DW(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_rm)
  );

  // request handshakes
  logic in_acc, cfg_acc, cfg_known, out_free, store_en;
  logic [SW-1:0] st_q, st_rm;

  assign in_bus.ready  = (state_r == ST_IDLE) && !cfg_bus.valid;
  assign cfg_bus.ready = (state_r == ST_IDLE);
  assign in_acc    = in_bus.valid && in_bus.ready;
  assign cfg_acc   = cfg_bus.valid && cfg_bus.ready;
  assign cfg_known = (cfg_bus.index == CFG_OUT_WIDTH) || (cfg_bus.index == CFG_OUT_HEIGHT);
  assign out_free  = !out_valid_r || out_bus.ready;
  assign store_en  = ((state_r == ST_CFG_GO) && cfg_zero) ||
                     ((state_r == ST_CFG_WAIT) && div_done);
  assign st_q      = (state_r == ST_CFG_GO) ? '0 : div_q;
  assign st_rm     = (state_r == ST_CFG_GO) ? '0 : div_rm;

  // next state and divider launch
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          if (cfg_known) begin
            state_nxt = ST_CFG_GO;
            step_nxt  = CS_FA;
          end
        end else if (in_acc) begin
          if (deg) begin
            if (deg_hit) state_nxt = ST_PUSH;
          end else if (region) begin
            state_nxt = ST_UPD;
          end
        end
      end
      ST_UPD: begin
        div_start = lastb_r;
        state_nxt = lastb_r ? ST_DIV : ST_IDLE;
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_CFG_GO: begin
        div_start = !cfg_zero;
        if (!cfg_zero) state_nxt = ST_CFG_WAIT;
      end
      ST_CFG_WAIT: begin
        state_nxt = ST_CFG_WAIT;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (store_en) begin
      unique case (step_r)
        CS_FA:   begin step_nxt = CS_FD;  state_nxt = ST_CFG_GO; end
        CS_FD:   begin step_nxt = CS_COL; state_nxt = ST_CFG_GO; end
        CS_COL:  begin step_nxt = CS_ROW; state_nxt = ST_CFG_GO; end
        CS_ROW:  begin step_nxt = CS_POS; state_nxt = ST_CFG_GO; end
        CS_POS:  begin step_nxt = CS_FA;  state_nxt = ST_IDLE;   end
        default: begin step_nxt = CS_FA;  state_nxt = ST_IDLE;   end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= CS_FA;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // configuration, factors and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ow_r   <= POS_W'(36);
      oh_r   <= POS_W'(36);
      fa_r   <= FW'(RESET_FACTOR);
      fd_r   <= FW'(RESET_FACTOR);
      c_r    <= '0; r_r  <= '0;
      bc_r   <= '0; br_r <= '0;
      lc_r   <= '0; lr_r <= '0;
      dcol_r <= '0; drow_r <= '0;
    end else begin
      if (cfg_acc) begin
        if (cfg_bus.index == CFG_OUT_WIDTH)  ow_r <= cfg_bus.data;
        if (cfg_bus.index == CFG_OUT_HEIGHT) oh_r <= cfg_bus.data;
      end else if (in_acc) begin
        c_r <= c_nxt;   r_r <= r_nxt;
        bc_r <= bc_nxt; br_r <= br_nxt;
        lc_r <= lc_nxt; lr_r <= lr_nxt;
        dcol_r <= dcol_nxt; drow_r <= drow_nxt;
      end
      if (store_en) begin
        unique case (step_r)
          CS_FA:  fa_r <= FW'(st_q);
          CS_FD:  fd_r <= FW'(st_q);
          CS_COL: begin bc_r <= PW'(st_q); lc_r <= FW'(st_rm); end
          CS_ROW: begin br_r <= PW'(st_q); lr_r <= FW'(st_rm); end
          CS_POS: begin
            dcol_r <= POS_W'(st_rm);
            drow_r <= (st_q > SW'(1 << POS_W)) ? {1'b1, {POS_W{1'b0}}} : (POS_W+1)'(st_q);
          end
          default: ;
        endcase
      end
    end
  end

  // hold block area for the mean division
  always_ff @(posedge clk) begin
    area_r <= {{FW{1'b0}}, fa_r} * {{FW{1'b0}}, fd_r};
  end

  // latch pixel request and result fields
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= SW'(in_bus.pixel_value & SMASK);
      first_r  <= first_c;
      lastb_r  <= lastb_c;
      addr_r   <= bc_c[AW-1:0];
      if (deg) begin
        res_r.col  <= dcol_c;
        res_r.row  <= POS_W'(drow_c);
        res_r.mean <= '0;
        res_r.last <= (drow_c == {1'b0, oh_r} - 1'b1) && (dcol_c == ow_r - 1'b1);
      end else begin
        res_r.col  <= POS_W'(bc_c);
        res_r.row  <= POS_W'(br_c);
        res_r.mean <= '0;
        res_r.last <= lastf_c;
      end
    end else if ((state_r == ST_DIV) && div_done) begin
      res_r.mean <= PIX_W'(div_q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_PUSH) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_PUSH) && out_free) begin
      out_r <= res_r;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.out_col    = out_r.col;
  assign out_bus.out_row    = out_r.row;
  assign out_bus.mean_value = out_r.mean;
  assign out_bus.frame_last = out_r.last;

endmodule

### rtl/boxavg_div.sv
// ----------------------------------------------------------------------------
// boxavg_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the last bit is in.
// ----------------------------------------------------------------------------
module boxavg_div #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient,
  output logic [DW-1:0] remainder
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] rem_r, quo_r, dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   shifted;
  logic          fits;

  // trial subtract of the shifted remainder
  assign shifted = {rem_r, quo_r[DW-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift one bit a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DW'(shifted - {1'b0, dvs_r}) : DW'(shifted);
      quo_r <= {quo_r[DW-2:0], fits};
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

### rtl/boxavg_mem.sv
// ----------------------------------------------------------------------------
// boxavg_mem: column partial sum store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module boxavg_mem #(
  parameter int DEPTH = 72,
  parameter int W     = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
